@@ hdl/cwc_pkg.sv @@
// cwc_pkg: shared widths, register codes and transaction types for the
// congestion window controller. No dependencies.
package cwc_pkg;

  localparam int WIN_W      = 16;
  localparam int IDX_W      = 20;
  localparam int WAIT_W     = 16;
  localparam int RTT_W      = 8;
  localparam int TMO_W      = 16;
  localparam int DUP_W      = 2;
  localparam int PROD_W     = WAIT_W + RTT_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int IN_FIELD_W  = IDX_W + 1;
  localparam int IN_TDATA_W  = ((IN_FIELD_W + 7) / 8) * 8;
  localparam int OUT_FIELD_W = 2 * WIN_W + 1 + IDX_W + 1 + 1 + IDX_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  localparam logic [WIN_W-1:0]  WIN_MAX  = '1;
  localparam logic [WAIT_W-1:0] WAIT_MAX = '1;
  localparam logic [DUP_W-1:0]  DUP_TRIGGER = DUP_W'(2);
  localparam logic [DUP_W-1:0]  DUP_MAX     = DUP_W'(3);

  localparam logic MODE_PACKET = 1'b0;
  localparam logic MODE_TICK   = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INIT_WINDOW  = 3'd0,
    REG_RTT_TICKS    = 3'd1,
    REG_TIMEOUT      = 3'd2,
    REG_FAST_RETX_ON = 3'd3,
    REG_FAST_RECV_ON = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic             mode;
    logic [IDX_W-1:0] packet_index;
    logic             packet_lost;
  } cwc_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] acked_total;
    logic             timed_out;
    logic             triple_duplicate;
    logic [IDX_W-1:0] lost_packet_index;
    logic             loss_outstanding;
    logic [WIN_W-1:0] threshold_now;
    logic [WIN_W-1:0] window_now;
  } cwc_result_t;

endpackage

@@ hdl/cwc_engine.sv @@
// cwc_engine: configuration registers and window state, with the per-item
// update logic. Depends on cwc_pkg.
module cwc_engine (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [cwc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cwc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          step,
  input  cwc_pkg::cwc_item_t            item,
  output cwc_pkg::cwc_result_t          result
);
  import cwc_pkg::*;

  logic [WIN_W-1:0]  init_win_r;
  logic [RTT_W-1:0]  rtt_r;
  logic [TMO_W-1:0]  tmo_r;
  logic              fast_retx_r;
  logic              fast_recv_r;

  logic [WIN_W-1:0]  window_r,   window_nxt;
  logic [WIN_W-1:0]  thresh_r,   thresh_nxt;
  logic [WAIT_W-1:0] waited_r,   waited_nxt;
  logic              pending_r,  pending_nxt;
  logic              earlier_r,  earlier_nxt;
  logic              confirm_r,  confirm_nxt;
  logic [DUP_W-1:0]  dup_r,      dup_nxt;
  logic [IDX_W-1:0]  lost_idx_r, lost_idx_nxt;
  logic [IDX_W-1:0]  acked_r,    acked_nxt;

  logic [PROD_W-1:0] wait_prod;
  logic              fast_cut;
  logic              fired;

  assign wait_prod = PROD_W'(waited_r) * PROD_W'(rtt_r);

  always_comb begin
    window_nxt   = window_r;
    thresh_nxt   = thresh_r;
    waited_nxt   = waited_r;
    pending_nxt  = pending_r;
    earlier_nxt  = earlier_r;
    confirm_nxt  = confirm_r;
    dup_nxt      = dup_r;
    lost_idx_nxt = lost_idx_r;
    acked_nxt    = acked_r;
    fast_cut     = 1'b0;
    fired        = 1'b0;
    if (item.mode == MODE_TICK) begin
      if (pending_r && confirm_r) begin
        thresh_nxt  = window_r >> 1;
        window_nxt  = fast_recv_r ? (window_r >> 1) : WIN_W'(1);
        pending_nxt = 1'b0;
        confirm_nxt = 1'b0;
        fast_cut    = 1'b1;
      end else if (pending_r || (waited_r != '0)) begin
        if (wait_prod >= PROD_W'(tmo_r)) begin
          waited_nxt  = '0;
          thresh_nxt  = window_r >> 1;
          window_nxt  = WIN_W'(1);
          pending_nxt = 1'b0;
          confirm_nxt = 1'b0;
          fired       = 1'b1;
        end else if (waited_r != WAIT_MAX) begin
          waited_nxt = waited_r + WAIT_W'(1);
        end
      end else if (window_r >= thresh_r) begin
        if (window_r != WIN_MAX) begin
          window_nxt = window_r + WIN_W'(1);
        end
      end else begin
        window_nxt = window_r[WIN_W-1] ? WIN_MAX : (window_r << 1);
      end
      earlier_nxt = pending_nxt;
      dup_nxt     = '0;
    end else if (!earlier_r && !confirm_r) begin
      if (item.packet_lost) begin
        if (!pending_r) begin
          pending_nxt  = 1'b1;
          lost_idx_nxt = item.packet_index;
        end
      end else if (pending_r) begin
        if ((dup_r == DUP_TRIGGER) && fast_retx_r) begin
          confirm_nxt = 1'b1;
        end else if (dup_r != DUP_MAX) begin
          dup_nxt = dup_r + DUP_W'(1);
        end
      end else begin
        acked_nxt = acked_r + IDX_W'(1);
      end
    end
  end

  always_comb begin
    result.window_now        = window_nxt;
    result.threshold_now     = thresh_nxt;
    result.loss_outstanding  = pending_nxt;
    result.lost_packet_index = lost_idx_nxt;
    result.triple_duplicate  = (item.mode == MODE_TICK) ? fast_cut : confirm_nxt;
    result.timed_out         = fired;
    result.acked_total       = acked_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_win_r  <= WIN_W'(1);
      rtt_r       <= RTT_W'(2);
      tmo_r       <= TMO_W'(4);
      fast_retx_r <= 1'b1;
      fast_recv_r <= 1'b1;
      window_r    <= WIN_W'(1);
      thresh_r    <= WIN_MAX;
      waited_r    <= '0;
      pending_r   <= 1'b0;
      earlier_r   <= 1'b0;
      confirm_r   <= 1'b0;
      dup_r       <= '0;
      lost_idx_r  <= '0;
      acked_r     <= '0;
    end else begin
      if (step) begin
        window_r   <= window_nxt;
        thresh_r   <= thresh_nxt;
        waited_r   <= waited_nxt;
        pending_r  <= pending_nxt;
        earlier_r  <= earlier_nxt;
        confirm_r  <= confirm_nxt;
        dup_r      <= dup_nxt;
        lost_idx_r <= lost_idx_nxt;
        acked_r    <= acked_nxt;
      end
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_INIT_WINDOW: begin
            init_win_r <= WIN_W'(cfg_data);
            window_r   <= WIN_W'(cfg_data);
          end
          REG_RTT_TICKS:    rtt_r       <= cfg_data[RTT_W-1:0];
          REG_TIMEOUT:      tmo_r       <= TMO_W'(cfg_data);
          REG_FAST_RETX_ON: fast_retx_r <= cfg_data[0];
          REG_FAST_RECV_ON: fast_recv_r <= cfg_data[0];
          default: begin
          end
        endcase
      end
    end
  end

  a_confirm_needs_pending: assert property (@(posedge clk) disable iff (!rst_n)
    confirm_r |-> pending_r)
    else $error("confirmed loss without a pending loss");

  a_cut_or_timeout: assert property (@(posedge clk) disable iff (!rst_n)
    !(fast_cut && fired))
    else $error("fast recovery and timeout in one transaction");

  a_timeout_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    fired |-> (item.mode == MODE_TICK))
    else $error("timeout outside a tick");

  a_earlier_blocks_ack: assert property (@(posedge clk) disable iff (!rst_n)
    (step && earlier_r && (item.mode == MODE_PACKET)) |=> $stable(acked_r))
    else $error("ack counted while an earlier loss is outstanding");

endmodule

@@ hdl/congestion_window_controller_unit.sv @@
// congestion_window_controller_unit: top level with input and result
// registers around cwc_engine. Depends on cwc_pkg and cwc_engine.
//
// Usage:
//   in_*  : one transaction per packet report or round tick. in_tuser is the
//           mode (0 packet, 1 tick); in_tdata carries index and loss flag.
//   out_* : one result transaction for every input transaction, in order.
//   cfg_* : register writes, always ready. Writes are to be taken only while
//           the unit is idle; the user must ensure this, the unit does not.
// Each transaction goes through the input register, state update and result
// register. Throughput: one transaction per cycle while out_tready is high.
// When out_tready is low the result register holds; the input register
// still takes one more transaction, then in_tready drops until the result
// is taken. Reset (rst_n low, synchronous) empties both registers, loads
// the register defaults and returns the window to its initial value.
module congestion_window_controller_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [19:0] packet_index, [20] packet_lost, [23:21] zero
  input  logic [cwc_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [0] mode
  input  logic                           in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [15:0] window_now, [31:16] threshold_now, [32] loss_outstanding,
  // [52:33] lost_packet_index, [53] triple_duplicate, [54] timed_out,
  // [74:55] acked_total, [79:75] zero
  output logic [cwc_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cwc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cwc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import cwc_pkg::*;

  cwc_item_t              item_r;
  logic                   item_valid_r;
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                   advance;
  logic                   step;
  logic                   in_fire;
  cwc_result_t            result;

  assign advance   = !out_valid_r || out_tready;
  assign step      = item_valid_r && advance;
  assign in_tready = !item_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  cwc_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (step),
    .item      (item_r),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_fire) begin
      item_valid_r <= 1'b1;
    end else if (step) begin
      item_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.mode         <= in_tuser;
      item_r.packet_index <= in_tdata[IDX_W-1:0];
      item_r.packet_lost  <= in_tdata[IDX_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= OUT_TDATA_W'(result);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_step_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid_r)
    else $error("processed transaction produced no result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !step)
    else $error("stalled result overwritten");

  a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (item_valid_r && out_valid_r && !out_tready) |-> !in_tready)
    else $error("input taken with both registers full");

endmodule

@@ dv/tb_top.sv @@
// tb_top: self-checking testbench for congestion_window_controller_unit, with a directed
// table and random rounds of transactions, each checked against the table or a predictor.
// Depends on cwc_pkg and the unit's RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cwc_pkg::*;

  localparam int IDLE_LIMIT     = 2000;
  localparam int GAP_MAX        = 17;
  localparam int LONG_HOLD      = 300;
  localparam int DRAIN_CYCLES   = 4;
  localparam int PHASE_ITEMS    = 100;
  localparam int RANDOM_PHASES  = 10;
  localparam int ZERO_RTT_TICKS = 60;
  localparam int PRINT_LIMIT    = 100;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  // [19:0] packet_index, [20] packet_lost, [23:21] zero
  logic [IN_TDATA_W-1:0]  in_tdata;
  // [0] mode
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  // [15:0] window_now, [31:16] threshold_now, [32] loss_outstanding,
  // [52:33] lost_packet_index, [53] triple_duplicate, [54] timed_out,
  // [74:55] acked_total, [79:75] zero
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  congestion_window_controller_unit dut (.*);

  typedef struct {
    logic             mode;
    logic [IDX_W-1:0] index;
    logic             lost;
    bit               typed;
    cwc_result_t      want;
  } stim_row_t;

  cwc_result_t window_results_due[$];
  int          mismatches;
  bit          steady;
  bit          long_hold_due;

  // predictor settings and state
  logic [WIN_W-1:0]  set_init_window;
  logic [RTT_W-1:0]  set_rtt;
  logic [TMO_W-1:0]  set_timeout;
  logic              set_fast_retx;
  logic              set_fast_recv;
  logic [WIN_W-1:0]  est_window;
  logic [WIN_W-1:0]  est_threshold;
  logic [WAIT_W-1:0] est_waited;
  logic              est_loss_pending;
  logic              est_loss_carried;
  logic              est_loss_confirmed;
  logic [DUP_W-1:0]  est_dups;
  logic [IDX_W-1:0]  est_lost_index;
  logic [IDX_W-1:0]  est_acks;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic cwc_result_t next_window_result(input logic m,
                                                     input logic [IDX_W-1:0] idx,
                                                     input logic lost);
    cwc_result_t      r;
    logic             cut;
    logic             fired;
    logic [PROD_W-1:0] product;
    cut = 1'b0;
    fired = 1'b0;
    if (m == MODE_TICK) begin
      product = PROD_W'(est_waited) * PROD_W'(set_rtt);
      if (est_loss_pending && est_loss_confirmed) begin
        est_threshold = est_window >> 1;
        est_window = set_fast_recv ? est_threshold : WIN_W'(1);
        est_loss_pending = 1'b0;
        est_loss_confirmed = 1'b0;
        cut = 1'b1;
      end else if (est_loss_pending || est_waited != '0) begin
        if (product >= PROD_W'(set_timeout)) begin
          est_waited = '0;
          est_threshold = est_window >> 1;
          est_window = WIN_W'(1);
          est_loss_pending = 1'b0;
          est_loss_confirmed = 1'b0;
          fired = 1'b1;
        end else if (est_waited != WAIT_MAX) begin
          est_waited = est_waited + WAIT_W'(1);
        end
      end else if (est_window >= est_threshold) begin
        if (est_window != WIN_MAX) est_window = est_window + WIN_W'(1);
      end else if (est_window > (WIN_MAX >> 1)) begin
        est_window = WIN_MAX;
      end else begin
        est_window = est_window << 1;
      end
      est_loss_carried = est_loss_pending;
      est_dups = '0;
    end else if (!est_loss_carried && !est_loss_confirmed) begin
      if (lost) begin
        if (!est_loss_pending) begin
          est_loss_pending = 1'b1;
          est_lost_index = idx;
        end
      end else if (est_loss_pending) begin
        if (est_dups == DUP_TRIGGER && set_fast_retx) est_loss_confirmed = 1'b1;
        else if (est_dups != DUP_MAX) est_dups = est_dups + DUP_W'(1);
      end else begin
        est_acks = est_acks + IDX_W'(1);
      end
    end
    r.window_now        = est_window;
    r.threshold_now     = est_threshold;
    r.loss_outstanding  = est_loss_pending;
    r.lost_packet_index = est_lost_index;
    r.triple_duplicate  = (m == MODE_TICK) ? cut : est_loss_confirmed;
    r.timed_out         = fired;
    r.acked_total       = est_acks;
    return r;
  endfunction

  function automatic cwc_result_t typed_result(input logic [WIN_W-1:0] w,
                                               input logic [WIN_W-1:0] thr,
                                               input logic lo,
                                               input logic [IDX_W-1:0] li,
                                               input logic dup3,
                                               input logic tmo_hit,
                                               input logic [IDX_W-1:0] acks);
    cwc_result_t r;
    r.window_now        = w;
    r.threshold_now     = thr;
    r.loss_outstanding  = lo;
    r.lost_packet_index = li;
    r.triple_duplicate  = dup3;
    r.timed_out         = tmo_hit;
    r.acked_total       = acks;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) $display("tb_top: mismatch at %0t: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  task automatic offer_item(input logic m, input logic [IDX_W-1:0] idx, input logic lost,
                            input bit typed, input cwc_result_t want);
    int          gap;
    cwc_result_t due;
    gap = steady ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= m;
    in_tdata  <= IN_TDATA_W'({lost, idx});
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    due = next_window_result(m, idx, lost);
    window_results_due.insert(window_results_due.size(), typed ? want : due);
  endtask

  task automatic write_setting(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    while (window_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_INIT_WINDOW: begin
        set_init_window = data[WIN_W-1:0];
        est_window = data[WIN_W-1:0];
      end
      REG_RTT_TICKS:    set_rtt = data[RTT_W-1:0];
      REG_TIMEOUT:      set_timeout = data[TMO_W-1:0];
      REG_FAST_RETX_ON: set_fast_retx = data[0];
      REG_FAST_RECV_ON: set_fast_recv = data[0];
      default: ;
    endcase
  endtask

  // result side: random back-pressure, one long hold on request
  initial begin
    int          stall;
    cwc_result_t got;
    cwc_result_t want;
    forever begin
      if (long_hold_due) begin
        long_hold_due = 1'b0;
        stall = LONG_HOLD;
      end else begin
        stall = steady ? 0 : $urandom_range(0, GAP_MAX);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (out_tvalid !== 1'b1) @(posedge clk);
      got = cwc_result_t'(out_tdata[OUT_FIELD_W-1:0]);
      if (window_results_due.size() == 0) begin
        report_mismatch("result transaction with nothing expected");
      end else begin
        want = window_results_due.pop_front();
        check_field("window_now", 32'(got.window_now), 32'(want.window_now));
        check_field("threshold_now", 32'(got.threshold_now), 32'(want.threshold_now));
        check_field("loss_outstanding", 32'(got.loss_outstanding), 32'(want.loss_outstanding));
        check_field("lost_packet_index", 32'(got.lost_packet_index),
                    32'(want.lost_packet_index));
        check_field("triple_duplicate", 32'(got.triple_duplicate), 32'(want.triple_duplicate));
        check_field("timed_out", 32'(got.timed_out), 32'(want.timed_out));
        check_field("acked_total", 32'(got.acked_total), 32'(want.acked_total));
      end
    end
  end

  // watchdog on cycles with no transaction on any channel
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid === 1'b1 && in_tready === 1'b1) ||
          (out_tvalid === 1'b1 && out_tready === 1'b1) ||
          (cfg_valid === 1'b1 && cfg_ready === 1'b1))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    stim_row_t        directed_rows[$];
    int               phase_items;
    int               n;
    int               kind;
    logic [IDX_W-1:0] base;
    logic [WIN_W-1:0] iw;
    logic [RTT_W-1:0] rtt;
    logic [TMO_W-1:0] tmo;
    logic             frx;
    logic             frec;

    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= MODE_PACKET;
    cfg_valid <= 1'b0;
    cfg_index <= REG_INIT_WINDOW;
    cfg_data  <= '0;
    mismatches = 0;
    steady = 1'b0;
    long_hold_due = 1'b0;

    set_init_window = WIN_W'(1);
    set_rtt = RTT_W'(2);
    set_timeout = TMO_W'(4);
    set_fast_retx = 1'b1;
    set_fast_recv = 1'b1;
    est_window = set_init_window;
    est_threshold = WIN_MAX;
    est_waited = '0;
    est_loss_pending = 1'b0;
    est_loss_carried = 1'b0;
    est_loss_confirmed = 1'b0;
    est_dups = '0;
    est_lost_index = '0;
    est_acks = '0;

    // defaults after reset; fast recovery then a timed-out loss
    directed_rows.insert(directed_rows.size(), '{MODE_PACKET, IDX_W'(0), 1'b0, 1'b1,
      typed_result(WIN_W'(1), 16'hFFFF, 1'b0, IDX_W'(0), 1'b0, 1'b0, IDX_W'(1))});
    directed_rows.insert(directed_rows.size(), '{MODE_TICK, IDX_W'(0), 1'b0, 1'b1,
      typed_result(WIN_W'(2), 16'hFFFF, 1'b0, IDX_W'(0), 1'b0, 1'b0, IDX_W'(1))});
    directed_rows.insert(directed_rows.size(), '{MODE_PACKET, IDX_W'(20'hFFFFF), 1'b0, 1'b1,
      typed_result(WIN_W'(2), 16'hFFFF, 1'b0, IDX_W'(0), 1'b0, 1'b0, IDX_W'(2))});
    directed_rows.insert(directed_rows.size(), '{MODE_PACKET, IDX_W'(20'hFFFFF), 1'b1, 1'b1,
      typed_result(WIN_W'(2), 16'hFFFF, 1'b1, 20'hFFFFF, 1'b0, 1'b0, IDX_W'(2))});
    directed_rows.insert(directed_rows.size(), '{MODE_PACKET, IDX_W'(0), 1'b1, 1'b1,
      typed_result(WIN_W'(2), 16'hFFFF, 1'b1, 20'hFFFFF, 1'b0, 1'b0, IDX_W'(2))});
    directed_rows.insert(directed_rows.size(), '{MODE_PACKET, IDX_W'(1), 1'b0, 1'b0, '0});
    directed_rows.insert(directed_rows.size(), '{MODE_PACKET, IDX_W'(2), 1'b0, 1'b0, '0});
    directed_rows.insert(directed_rows.size(), '{MODE_PACKET, IDX_W'(3), 1'b0, 1'b1,
      typed_result(WIN_W'(2), 16'hFFFF, 1'b1, 20'hFFFFF, 1'b1, 1'b0, IDX_W'(2))});
    directed_rows.insert(directed_rows.size(), '{MODE_PACKET, IDX_W'(4), 1'b0, 1'b0, '0});
    directed_rows.insert(directed_rows.size(), '{MODE_TICK, IDX_W'(20'hFFFFF), 1'b1, 1'b1,
      typed_result(WIN_W'(1), WIN_W'(1), 1'b0, 20'hFFFFF, 1'b1, 1'b0, IDX_W'(2))});
    directed_rows.insert(directed_rows.size(), '{MODE_TICK, IDX_W'(0), 1'b0, 1'b0, '0});
    directed_rows.insert(directed_rows.size(), '{MODE_PACKET, IDX_W'(20'h12345), 1'b1, 1'b0,
      '0});
    directed_rows.insert(directed_rows.size(), '{MODE_TICK, IDX_W'(0), 1'b0, 1'b0, '0});
    directed_rows.insert(directed_rows.size(), '{MODE_PACKET, IDX_W'(20'h54321), 1'b1, 1'b0,
      '0});
    directed_rows.insert(directed_rows.size(), '{MODE_PACKET, IDX_W'(6), 1'b0, 1'b0, '0});
    directed_rows.insert(directed_rows.size(), '{MODE_TICK, IDX_W'(0), 1'b0, 1'b0, '0});
    directed_rows.insert(directed_rows.size(), '{MODE_TICK, IDX_W'(0), 1'b0, 1'b1,
      typed_result(WIN_W'(1), WIN_W'(1), 1'b0, 20'h12345, 1'b0, 1'b1, IDX_W'(2))});
    directed_rows.insert(directed_rows.size(), '{MODE_TICK, IDX_W'(0), 1'b0, 1'b0, '0});

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      offer_item(directed_rows[i].mode, directed_rows[i].index, directed_rows[i].lost,
                 directed_rows[i].typed, directed_rows[i].want);
    in_tvalid <= 1'b0;

    // zero round trip: waited rounds keep climbing and never time out
    write_setting(REG_RTT_TICKS, CFG_DATA_W'(0));
    write_setting(REG_TIMEOUT, CFG_DATA_W'(1));
    write_setting(REG_FAST_RETX_ON, CFG_DATA_W'(0));
    steady = 1'b1;
    offer_item(MODE_PACKET, IDX_W'($urandom()), 1'b1, 1'b0, '0);
    repeat (ZERO_RTT_TICKS)
      offer_item(MODE_TICK, IDX_W'($urandom()), logic'($urandom_range(0, 1)), 1'b0, '0);
    in_tvalid <= 1'b0;
    steady = 1'b0;

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin
          iw = WIN_MAX; rtt = RTT_W'(1); tmo = TMO_W'(0); frx = 1'b0; frec = 1'b0;
        end
        1: begin
          iw = WIN_W'(0); rtt = '1; tmo = '1; frx = 1'b1; frec = 1'b1;
        end
        2: begin
          iw = WIN_W'(1); rtt = RTT_W'(1); tmo = TMO_W'(1); frx = 1'b1; frec = 1'b0;
        end
        3: begin
          iw = WIN_W'(16'h8000); rtt = RTT_W'(0); tmo = TMO_W'(0); frx = 1'b0; frec = 1'b1;
        end
        default: begin
          iw   = ($urandom_range(0, 1) == 0) ? WIN_W'($urandom_range(1, 20))
                                            : WIN_W'($urandom_range(1, 65535));
          rtt  = ($urandom_range(0, 3) == 0) ? RTT_W'($urandom_range(1, 255))
                                            : RTT_W'($urandom_range(1, 4));
          tmo  = ($urandom_range(0, 3) == 0) ? TMO_W'($urandom_range(0, 65535))
                                            : TMO_W'($urandom_range(0, 12));
          frx  = logic'($urandom_range(0, 1));
          frec = logic'($urandom_range(0, 1));
        end
      endcase
      // upper data bits of the narrow registers are don't-care, so randomise them
      write_setting(REG_INIT_WINDOW, CFG_DATA_W'(iw));
      write_setting(REG_RTT_TICKS, {(CFG_DATA_W - RTT_W)'($urandom()), rtt});
      write_setting(REG_TIMEOUT, CFG_DATA_W'(tmo));
      write_setting(REG_FAST_RETX_ON, {(CFG_DATA_W - 1)'($urandom()), frx});
      write_setting(REG_FAST_RECV_ON, {(CFG_DATA_W - 1)'($urandom()), frec});
      for (int k = int'(REG_FAST_RECV_ON) + 1; k < (1 << CFG_IDX_W); k++)
        write_setting(CFG_IDX_W'(k), CFG_DATA_W'($urandom()));

      steady = ($urandom_range(0, 3) == 0);
      if (p == 2) begin
        steady = 1'b0;
        long_hold_due = 1'b1;
      end

      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
          offer_item(logic'($urandom_range(0, 1)), IDX_W'($urandom()),
                     logic'($urandom_range(0, 1)), 1'b0, '0);
          phase_items++;
        end else begin
          n = $urandom_range(0, 9);
          base = IDX_W'($urandom());
          for (int j = 0; j < n; j++)
            offer_item(MODE_PACKET, base + IDX_W'(j), logic'($urandom_range(0, 5) == 0),
                       1'b0, '0);
          offer_item(MODE_TICK, IDX_W'($urandom()), logic'($urandom_range(0, 1)), 1'b0, '0);
          phase_items += n + 1;
        end
      end
      in_tvalid <= 1'b0;
    end

    steady = 1'b0;
    while (window_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES * 4) @(posedge clk);
    if (mismatches == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule

@@ congestion_window_controller_unit.f @@
hdl/cwc_pkg.sv
hdl/cwc_engine.sv
hdl/congestion_window_controller_unit.sv
dv/tb_top.sv
